/* rtl/pmm_pkg.sv */
// Package for the polynomial multiplier modulo 2^16.
// Holds request and status codes, controller states and default sizes.
`timescale 1ns / 1ps
`default_nettype none
package pmm_pkg;
    localparam int NUM_COEFFS_DEF = 256;
    localparam int COEFF_W = 16;
    localparam int INDEX_W = 9;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_NOT_READY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;
endpackage
`default_nettype wire

/* rtl/pmm_cell.sv */
// One cell of the transposed product chain: holds one second-operand coefficient
// and a partial sum handed to its lower neighbor each cycle. Uses pmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmm_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clear,
    input  wire logic                        load_b,
    input  wire logic [pmm_pkg::COEFF_W-1:0] b_in,
    input  wire logic [pmm_pkg::COEFF_W-1:0] x,
    input  wire logic [pmm_pkg::COEFF_W-1:0] sum_in,
    output logic      [pmm_pkg::COEFF_W-1:0] sum_out
);
    logic [pmm_pkg::COEFF_W-1:0]   b_reg;
    logic [pmm_pkg::COEFF_W-1:0]   sum_reg;
    logic [pmm_pkg::COEFF_W-1:0]   sum_next;
    logic [2*pmm_pkg::COEFF_W-1:0] prod;

    always_comb
    begin
        prod     = x * b_reg;
        sum_next = sum_in + prod[pmm_pkg::COEFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_reg <= b_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (clear)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;
endmodule
`default_nettype wire

/* rtl/poly_mul_mod_2_16_top.sv */
// Latency: load, read and unused requests give their result one cycle after start.
// Compute: the first operand streams from its memory, one coefficient a cycle,
// through the cell chain, then the chain drains.
// Throughput: one load or read per cycle while busy is low; busy is high while a compute runs.
// Reset clears control state and the product-ready flag; memories stay unknown.
`timescale 1ns / 1ps
`default_nettype none
module poly_mul_mod_2_16_top #(
    parameter int NUM_COEFFS = pmm_pkg::NUM_COEFFS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic [pmm_pkg::INDEX_W-1:0]  index,
    input  wire logic [pmm_pkg::COEFF_W-1:0]  key_coeff,
    input  wire logic [pmm_pkg::COEFF_W-1:0]  text_coeff,
    output logic                              done,
    output logic      [pmm_pkg::COEFF_W-1:0]  coeff,
    output logic      [1:0]                   status
);
    localparam int PROD_LEN = 2 * NUM_COEFFS - 1;
    localparam int AW = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
    localparam int PW = $clog2(PROD_LEN);
    localparam int CW = $clog2(PROD_LEN + 2);
    localparam int IW = 11;
    localparam int W = pmm_pkg::COEFF_W;

    pmm_pkg::state_t state_reg, state_next;
    logic          accept;
    logic          finish;
    logic [IW-1:0] idx_ext;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          v1_reg, in1_reg, v2_reg;
    logic [PW-1:0] addr1_reg, addr2_reg;
    logic [W-1:0]  a_q_reg, p_q_reg, x;
    logic          ready_reg;
    logic          done_reg, rd_ok_reg;
    logic [1:0]    status_reg;
    logic          clear;
    logic [W-1:0]  sums [0:NUM_COEFFS];
    logic [W-1:0]  amem [0:NUM_COEFFS-1];
    logic [W-1:0]  pmem [0:PROD_LEN-1];

    assign accept  = start && !busy;
    assign idx_ext = IW'(index);
    assign clear   = accept && (req_type == pmm_pkg::REQ_COMPUTE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmm_pkg::ST_IDLE: if (clear) state_next = pmm_pkg::ST_RUN;
            pmm_pkg::ST_RUN:  if (cnt_reg == CW'(PROD_LEN + 1)) state_next = pmm_pkg::ST_IDLE;
            default:          state_next = pmm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            pmm_pkg::ST_IDLE: busy = 1'b0;
            pmm_pkg::ST_RUN:
            begin
                busy   = 1'b1;
                finish = (cnt_reg == CW'(PROD_LEN + 1));
            end
            default:          busy = 1'b0;
        endcase
    end

    assign cnt_next = (state_reg == pmm_pkg::ST_RUN) ? cnt_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pmm_pkg::ST_IDLE;
            cnt_reg    <= '0;
            v1_reg     <= 1'b0;
            in1_reg    <= 1'b0;
            v2_reg     <= 1'b0;
            ready_reg  <= 1'b0;
            done_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
            status_reg <= pmm_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            v1_reg     <= (state_reg == pmm_pkg::ST_RUN) && (cnt_reg < CW'(PROD_LEN));
            in1_reg    <= cnt_reg < CW'(NUM_COEFFS);
            v2_reg     <= v1_reg;
            if (finish)
            begin
                ready_reg <= 1'b1;
            end
            done_reg   <= finish || (accept && !clear);
            rd_ok_reg  <= 1'b0;
            status_reg <= pmm_pkg::STAT_OK;
            if (accept)
            begin
                case (req_type)
                    pmm_pkg::REQ_LOAD:
                    begin
                        if (idx_ext >= IW'(NUM_COEFFS))
                        begin
                            status_reg <= pmm_pkg::STAT_RANGE;
                        end
                    end
                    pmm_pkg::REQ_READ:
                    begin
                        if (!ready_reg)
                        begin
                            status_reg <= pmm_pkg::STAT_NOT_READY;
                        end
                        else if (idx_ext >= IW'(PROD_LEN))
                        begin
                            status_reg <= pmm_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            rd_ok_reg <= 1'b1;
                        end
                    end
                    default: status_reg <= pmm_pkg::STAT_OK;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg <= cnt_reg[PW-1:0];
        addr2_reg <= addr1_reg;
        a_q_reg   <= amem[cnt_reg[AW-1:0]];
        if (accept && req_type == pmm_pkg::REQ_LOAD && idx_ext < IW'(NUM_COEFFS))
        begin
            amem[idx_ext[AW-1:0]] <= key_coeff;
        end
        if (accept && req_type == pmm_pkg::REQ_READ && idx_ext < IW'(PROD_LEN))
        begin
            p_q_reg <= pmem[idx_ext[PW-1:0]];
        end
        if (v2_reg)
        begin
            pmem[addr2_reg] <= sums[0];
        end
    end

    assign x = (v1_reg && in1_reg) ? a_q_reg : '0;
    assign sums[NUM_COEFFS] = '0;

    for (genvar j = 0; j < NUM_COEFFS; j++)
    begin : g_cell
        pmm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear),
            .load_b  (accept && req_type == pmm_pkg::REQ_LOAD && idx_ext == IW'(j)),
            .b_in    (text_coeff),
            .x       (x),
            .sum_in  (sums[j+1]),
            .sum_out (sums[j])
        );
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign coeff  = rd_ok_reg ? p_q_reg : '0;

`ifndef SYNTHESIS
    a_finish_ready: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> ready_reg)
        else $error("product flag not set after compute");
    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted transaction got no response");
    a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == pmm_pkg::STAT_NOT_READY) |-> !ready_reg)
        else $error("not-ready status with product present");
`endif
endmodule
`default_nettype wire
